[rtl/core/sfr_pkg.sv]
// shared types and constants for the stream find-and-replace core
package sfr_pkg;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;
  localparam int WORD_W              = 64;
  localparam int WORD_BYTES          = WORD_W / 8;
  localparam int LEN_W               = 4;
  localparam int CFG_IDX_W           = 2;
  localparam int CMD_FIFO_DEPTH      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;
  } cfg_wr_t;

endpackage

[rtl/core/sfr_front.sv]
// front end: window, pattern compare and classification into byte-run requests
module sfr_front #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF,
  parameter int CMD_BYTES       = 8,
  parameter int KW              = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfr_pkg::cfg_wr_t     cfg_wr,
  input  logic                 in_push,
  output logic                 in_full,
  input  sfr_pkg::in_item_t    in_item,
  output logic                 cmd_push,
  input  logic                 cmd_full,
  output logic [CMD_BYTES*8-1:0] cmd_bytes,
  output logic [KW-1:0]        cmd_count,
  output logic                 cmd_last
);
  import sfr_pkg::*;

  localparam int CW   = $clog2(MAX_PATTERN + 1);
  localparam int RMAX = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;
  localparam logic [LEN_W:0] MAXP_L = (LEN_W + 1)'(MAX_PATTERN);
  localparam logic [LEN_W-1:0] RMAX_L = LEN_W'(RMAX);

  logic [WORD_W-1:0] pat_bytes_r, rep_bytes_r;
  logic [LEN_W-1:0]  pat_len_r, rep_len_r;
  logic [7:0]        win_r   [MAX_PATTERN];
  logic [7:0]        win_nxt [MAX_PATTERN];
  logic [7:0]        nw      [MAX_PATTERN];
  logic [CW-1:0]     win_cnt_r, win_cnt_nxt;

  logic [LEN_W:0]    plen_w;
  logic [CW-1:0]     plen, wc, wn;
  logic [LEN_W-1:0]  rlen;
  logic              accept, is_full, is_match;
  logic [MAX_PATTERN-1:0] eq;

  // effective lengths, saturated
  always_comb begin
    if (pat_len_r == '0) begin
      plen_w = (LEN_W + 1)'(1);
    end else if ({1'b0, pat_len_r} > MAXP_L) begin
      plen_w = MAXP_L;
    end else begin
      plen_w = {1'b0, pat_len_r};
    end
    plen = CW'(plen_w);
    rlen = (rep_len_r > RMAX_L) ? RMAX_L : rep_len_r;
  end

  assign accept = in_push && !in_full;
  assign in_full = cmd_full;

  assign wc      = (win_cnt_r >= plen) ? '0 : win_cnt_r;
  assign wn      = wc + CW'(1);
  assign is_full = (wn == plen);

  // window with the new byte dropped in, compared byte for byte
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      nw[k] = (CW'(k) == wc) ? in_item.in_byte : win_r[k];
      if (CW'(k) >= plen) begin
        eq[k] = 1'b1;
      end else if (k < WORD_BYTES) begin
        eq[k] = (nw[k] == pat_bytes_r[(k % WORD_BYTES)*8 +: 8]);
      end else begin
        eq[k] = (nw[k] == 8'd0);
      end
    end
    is_match = is_full && (&eq);
  end

  // classify the item into one run of bytes for the back end
  always_comb begin
    cmd_bytes   = '0;
    cmd_count   = '0;
    cmd_last    = in_item.in_last;
    win_cnt_nxt = wn;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_nxt[k] = nw[k];
    end
    if (is_match) begin
      for (int k = 0; k < CMD_BYTES; k++) begin
        if (k < RMAX) begin
          cmd_bytes[k*8 +: 8] = rep_bytes_r[(k % WORD_BYTES)*8 +: 8];
        end
      end
      cmd_count   = KW'(rlen);
      win_cnt_nxt = '0;
    end else begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        cmd_bytes[k*8 +: 8] = nw[k];
      end
      if (in_item.in_last) begin
        cmd_count   = KW'(wn);
        win_cnt_nxt = '0;
      end else if (is_full) begin
        cmd_count   = KW'(1);
        win_cnt_nxt = wn - CW'(1);
        for (int k = 0; k < MAX_PATTERN - 1; k++) begin
          win_nxt[k] = nw[k+1];
        end
      end
    end
  end

  assign cmd_push = accept && ((cmd_count != '0) || in_item.in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= LEN_W'(1);
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
      win_cnt_r   <= '0;
    end else begin
      // a pattern length write discards pending window bytes
      if (cfg_wr.we && (cfg_wr.index == CFG_PATTERN_LENGTH)) begin
        win_cnt_r <= '0;
      end else if (accept) begin
        win_cnt_r <= win_cnt_nxt;
      end
      if (cfg_wr.we) begin
        case (cfg_wr.index)
          CFG_PATTERN_BYTES:      pat_bytes_r <= cfg_wr.data;
          CFG_PATTERN_LENGTH:     pat_len_r   <= cfg_wr.data[LEN_W-1:0];
          CFG_REPLACEMENT_BYTES:  rep_bytes_r <= cfg_wr.data;
          CFG_REPLACEMENT_LENGTH: rep_len_r   <= cfg_wr.data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  a_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    win_cnt_r < plen) else $error("window count reached pattern length");
  a_match_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_match && !cfg_wr.we |=> win_cnt_r == '0)
    else $error("window not cleared after match");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full) else $error("request pushed into full queue");

endmodule

[rtl/core/sfr_cmd_fifo.sv]
// short request queue between front and back end
module sfr_cmd_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  import sfr_pkg::*;

  localparam int AW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int NW = $clog2(CMD_FIFO_DEPTH + 1);

  logic [W-1:0]  mem_r [CMD_FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] num_r;
  logic          do_push, do_pop;

  assign full    = (num_r == NW'(CMD_FIFO_DEPTH));
  assign empty   = (num_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      num_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        num_r <= num_r + NW'(1);
      end else if (do_pop && !do_push) begin
        num_r <= num_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
    num_r <= NW'(CMD_FIFO_DEPTH)) else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (num_r == '0 || num_r == NW'(CMD_FIFO_DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

[rtl/core/sfr_back.sv]
// back end: serializes byte-run requests into single results with an output register
module sfr_back #(
  parameter int CMD_BYTES = 8,
  parameter int KW        = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_empty,
  output logic                   cmd_pop,
  input  logic [CMD_BYTES*8-1:0] cmd_bytes,
  input  logic [KW-1:0]          cmd_count,
  input  logic                   cmd_last,
  output logic                   out_empty,
  input  logic                   out_pop,
  output sfr_pkg::out_item_t     out_item
);
  import sfr_pkg::*;

  localparam int IW = (CMD_BYTES > 1) ? $clog2(CMD_BYTES) : 1;

  logic            out_vld_r;
  out_item_t       out_item_r, out_item_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic            load, at_end;

  assign load   = !cmd_empty && (!out_vld_r || out_pop);
  assign at_end = (cmd_count == '0) || (KW'(idx_r) == (cmd_count - KW'(1)));

  always_comb begin
    out_item_nxt = '0;
    idx_nxt      = idx_r + IW'(1);
    if (cmd_count == '0) begin
      // end-only marker
      out_item_nxt.out_last = 1'b1;
    end else begin
      out_item_nxt.out_byte  = cmd_bytes[idx_r*8 +: 8];
      out_item_nxt.out_valid = 1'b1;
      out_item_nxt.out_last  = cmd_last && at_end;
    end
    if (at_end) begin
      idx_nxt = '0;
    end
  end

  assign cmd_pop   = load && at_end;
  assign out_empty = !out_vld_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
        idx_r     <= idx_nxt;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= out_item_nxt;
    end
  end

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_item.out_valid |-> out_item.out_last)
    else $error("end-only marker without last");
  a_idx_reset_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> idx_r == '0) else $error("byte index not rewound");

endmodule

[rtl/core/stream_find_and_replace_core.sv]
// top level of the stream find-and-replace core
// path: a request is written into the queue, then loaded from its head into the output
//   register on the out_ ports once that register is empty or being popped
// throughput: one input byte per cycle while the queue is not full; a request with n
//   results holds the back end until all n are loaded, the two-entry queue absorbs short bursts
// reset: synchronous on rst_n low; window empties, queue and output empty, regs default
module stream_find_and_replace_core #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfr_pkg::WORD_W-1:0]         cfg_data,
  // input byte stream
  input  logic                               in_push,
  output logic                               in_full,
  input  sfr_pkg::in_item_t                  in_item,
  // result stream
  output logic                               out_empty,
  input  logic                               out_pop,
  output sfr_pkg::out_item_t                 out_item
);
  import sfr_pkg::*;

  // replacement length caps at MAX_REPLACEMENT, and at eight since the register holds eight bytes
  localparam int RMAX      = (MAX_REPLACEMENT < WORD_BYTES) ? MAX_REPLACEMENT : WORD_BYTES;
  // one request carries a whole run: a replacement or a window flush
  localparam int CMD_BYTES = (MAX_PATTERN > RMAX) ? MAX_PATTERN : RMAX;
  localparam int KW        = $clog2(CMD_BYTES + 1);
  localparam int CMD_W     = CMD_BYTES * 8 + KW + 1;

  cfg_wr_t                 cfg_wr;
  logic                    f_push, f_full, b_pop, b_empty;
  logic [CMD_BYTES*8-1:0]  f_bytes, b_bytes;
  logic [KW-1:0]           f_count, b_count;
  logic                    f_last, b_last;
  logic [CMD_W-1:0]        q_wr, q_rd;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // front: window shift register, parallel compare, request build
  sfr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .CMD_BYTES       (CMD_BYTES),
    .KW              (KW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_push  (f_push),
    .cmd_full  (f_full),
    .cmd_bytes (f_bytes),
    .cmd_count (f_count),
    .cmd_last  (f_last)
  );

  // requests packed flat through the queue
  assign q_wr = {f_bytes, f_count, f_last};
  assign {b_bytes, b_count, b_last} = q_rd;

  sfr_cmd_fifo #(
    .W (CMD_W)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_data (q_wr),
    .full    (f_full),
    .pop     (b_pop),
    .rd_data (q_rd),
    .empty   (b_empty)
  );

  // back: one result per cycle from the head request while results are being popped
  sfr_back #(
    .CMD_BYTES (CMD_BYTES),
    .KW        (KW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (b_empty),
    .cmd_pop   (b_pop),
    .cmd_bytes (b_bytes),
    .cmd_count (b_count),
    .cmd_last  (b_last),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // a stalled result must hold until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("result changed while stalled");
  // full on the input only when the queue is full
  a_full_tracks_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_full == f_full) else $error("input full mismatch");
  // nothing queued and nothing shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full) else $error("not empty after reset");

endmodule
